// File: hdl/mvcs_pkg.sv
// Shared types and constants of the run statistics block.
package mvcs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 17;
    localparam int SUM_W    = 32;
    localparam int SUMSQ_W  = 47;
    localparam int MEAN_W   = 32;
    localparam int VAR_W    = 47;
    localparam int STD_W    = 32;
    localparam int CV_W     = 32;
    localparam int DIFF_W   = 63;
    localparam int NN_W     = 33;

    localparam int MAX_SAMPLES_DEF = 65536;

    // Shared divider: dividend, divisor and bit counter widths.
    localparam int DIV_DW = 80;
    localparam int DIV_VW = 34;
    localparam int DIV_CW = 7;

    // Square root: radicand, remainder and step counter widths.
    localparam int ROOT_RW = 64;
    localparam int ROOT_MW = 35;
    localparam int ROOT_CW = 5;

    localparam int TDATA_W = 160;

    localparam logic [CV_W-1:0] CV_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [CV_W-1:0] CV_NEG_SAT = 32'h8000_0000;

    // One finished run as handed from the accumulator to the back end.
    typedef struct packed {
        logic [COUNT_W-1:0]        n;
        logic signed [SUM_W-1:0]   sum;
        logic [SUMSQ_W-1:0]        sumsq;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SQR,
        ST_MEAN,
        ST_VAR,
        ST_ROOT,
        ST_CV,
        ST_DONE
    } t_state;

endpackage

// File: hdl/mean_variance_cv_stats.sv
// Top level of the run statistics block: mean, variance, standard deviation and cv.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: sample; tlast: last sample of the run
//  m_axis   | out       | tdata: mean, variance, std, cv, count; tuser: cv_invalid
//
// The accumulator takes one sample request per cycle with no gaps while the job queue has room.
// The back end handles one run at a time: three setup steps, up to three
// divisions on one shared radix-2 divider (no cv division for a zero mean)
// and a square root. A two-entry job queue lets the accumulator run ahead of it.
// Reset is synchronous and active low and clears the accumulators, queue and
// sequencer. Input ready drops only while the job queue is full; a result
// held on the output stalls the back end but not the accumulator.
module mean_variance_cv_stats #(
    parameter int MAX_SAMPLES = mvcs_pkg::MAX_SAMPLES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tdata: [15:0] sample
    input  logic [15:0]                  i_s_axis_tdata,
    input  logic                         i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // tdata: [31:0] mean_q16, [78:32] variance_q16, [110:79] std_q16,
    //        [142:111] cv_q16, [159:143] count
    output logic [mvcs_pkg::TDATA_W-1:0] o_m_axis_tdata,
    // tuser: [0] cv_invalid
    output logic                         o_m_axis_tuser
);
    import mvcs_pkg::*;

    t_job w_push_job, w_pop_job;
    logic w_push, w_pop, w_full, w_empty;

    mvcs_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_sample ($signed(i_s_axis_tdata)),
        .i_last   (i_s_axis_tlast),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    mvcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    mvcs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_job    (w_pop_job),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser)
    );

    // A finished run is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    // A zero mean always carries the invalid flag.
    a_zero_mean_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[31:0] == '0) |-> o_m_axis_tuser)
        else $error("zero mean without cv_invalid");

    // Every result covers at least one sample.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[159:143] != '0)
        else $error("result with zero count");

endmodule

// File: hdl/mvcs_front.sv
// Front end: accumulates count, sum and sum of squares and emits one job per run.
module mvcs_front #(
    parameter int MAX_SAMPLES = mvcs_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mvcs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    input  logic                                i_full,
    output logic                                o_push,
    output mvcs_pkg::t_job                      o_job
);
    import mvcs_pkg::*;

    logic [COUNT_W-1:0]       r_cnt, n_cnt;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [SUMSQ_W-1:0]       r_sumsq, n_sumsq;
    logic signed [2*SAMPLE_W-1:0] w_sq;
    logic w_acc;
    logic w_take;

    assign o_ready = !i_full;
    assign w_take  = i_valid && !i_full;
    assign w_sq    = i_sample * i_sample;
    assign w_acc   = r_cnt < COUNT_W'(MAX_SAMPLES);

    always_comb begin
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        if (w_acc) begin
            n_cnt   = r_cnt + COUNT_W'(1);
            n_sum   = r_sum + SUM_W'(i_sample);
            n_sumsq = r_sumsq + SUMSQ_W'($unsigned(w_sq));
        end
    end

    assign o_push      = w_take && i_last;
    assign o_job.n     = n_cnt;
    assign o_job.sum   = n_sum;
    assign o_job.sumsq = n_sumsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
        end else if (w_take) begin
            if (i_last) begin
                r_cnt   <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
            end else begin
                r_cnt   <= n_cnt;
                r_sum   <= n_sum;
                r_sumsq <= n_sumsq;
            end
        end
    end

endmodule

// File: hdl/mvcs_queue.sv
// Two-entry job queue between the accumulator and the back end.
module mvcs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mvcs_pkg::t_job i_job,
    input  logic           i_pop,
    output mvcs_pkg::t_job o_job,
    output logic           o_empty,
    output logic           o_full
);
    import mvcs_pkg::*;

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_level;
    logic       w_push, w_pop;

    assign o_empty = r_level == 2'd0;
    assign o_full  = r_level == 2'd2;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop) r_rd <= !r_rd;
            if (w_push && !w_pop) begin
                r_level <= r_level + 2'd1;
            end else if (w_pop && !w_push) begin
                r_level <= r_level - 2'd1;
            end
        end
    end

endmodule

// File: hdl/mvcs_div.sv
// Restoring divider, one quotient bit per cycle.
module mvcs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mvcs_pkg::DIV_DW-1:0] i_dividend,
    input  logic [mvcs_pkg::DIV_VW-1:0] i_divisor,
    output logic                        o_done,
    output logic [mvcs_pkg::DIV_DW-1:0] o_quot
);
    import mvcs_pkg::*;

    logic                r_busy, r_done;
    logic [DIV_CW-1:0]   r_cnt;
    logic [DIV_VW:0]     r_rem;
    logic [DIV_DW-1:0]   r_quo;
    logic [DIV_VW-1:0]   r_dvs;
    logic [DIV_VW:0]     w_sh;
    logic                w_ge;

    assign w_sh   = {r_rem[DIV_VW-1:0], r_quo[DIV_DW-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_dvs}) : w_sh;
            r_quo <= {r_quo[DIV_DW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_DW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: hdl/mvcs_back.sv
// Back end: sequencer for mean, variance, square root and cv, with the output register.
module mvcs_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  mvcs_pkg::t_job               i_job,
    output logic                         o_pop,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [mvcs_pkg::TDATA_W-1:0] o_tdata,
    output logic                         o_tuser
);
    import mvcs_pkg::*;

    t_state r_state, n_state;

    t_job                 r_job;
    logic [SUM_W-1:0]     w_abs_sum;
    logic [DIFF_W-1:0]    r_acc;
    logic [NN_W-1:0]      r_nn;
    logic [MEAN_W-1:0]    r_mean;
    logic [MEAN_W-1:0]    w_abs_mean;
    logic [VAR_W-1:0]     r_var;
    logic [STD_W-1:0]     r_std;
    logic [CV_W-1:0]      r_cv;
    logic                 r_bad;

    logic [ROOT_RW-1:0]   r_rad;
    logic [ROOT_MW-1:0]   r_rem;
    logic [STD_W-1:0]     r_root;
    logic [ROOT_CW-1:0]   r_rcnt;
    logic [ROOT_MW-1:0]   w_rsh, w_trial;
    logic                 w_rge;
    logic [STD_W-1:0]     w_root_nx;

    logic                 w_start;
    logic [DIV_DW-1:0]    w_dividend;
    logic [DIV_VW-1:0]    w_divisor;
    logic                 w_done;
    logic [DIV_DW-1:0]    w_quot;
    logic                 w_out_free;
    logic                 r_out_valid;
    logic                 w_load;

    assign w_abs_sum  = r_job.sum[SUM_W-1] ? (~r_job.sum + SUM_W'(1)) : r_job.sum;
    assign w_abs_mean = r_mean[MEAN_W-1] ? (~r_mean + MEAN_W'(1)) : r_mean;

    // One square root step: bring down two radicand bits, try root*4+1.
    assign w_rsh     = {r_rem[ROOT_MW-3:0], r_rad[ROOT_RW-1 -: 2]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_rge     = w_rsh >= w_trial;
    assign w_root_nx = {r_root[STD_W-2:0], w_rge};

    assign w_out_free = !r_out_valid || i_tready;

    mvcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_start    = 1'b0;
        w_dividend = '0;
        w_divisor  = '0;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_MUL_LO;
                end
            end
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_SQR;
            ST_SQR: begin
                w_start    = 1'b1;
                w_dividend = DIV_DW'({w_abs_sum, 16'h0});
                w_divisor  = DIV_VW'(r_job.n);
                n_state    = ST_MEAN;
            end
            ST_MEAN: begin
                if (w_done) begin
                    w_start    = 1'b1;
                    w_dividend = DIV_DW'({r_acc, 16'h0});
                    w_divisor  = DIV_VW'(r_nn);
                    n_state    = ST_VAR;
                end
            end
            ST_VAR: begin
                if (w_done) n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (r_rcnt == '0) begin
                    if (r_mean == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        w_start    = 1'b1;
                        w_dividend = DIV_DW'({w_root_nx, 16'h0});
                        w_divisor  = DIV_VW'(w_abs_mean);
                        n_state    = ST_CV;
                    end
                end
            end
            ST_CV: begin
                if (w_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: r_job <= i_job;
            ST_MUL_LO: begin
                r_acc <= DIFF_W'(r_job.n * r_job.sumsq[23:0]);
                r_nn  <= NN_W'(r_job.n * r_job.n);
            end
            ST_MUL_HI: begin
                r_acc <= r_acc + (DIFF_W'(r_job.n * r_job.sumsq[SUMSQ_W-1:24]) << 24);
            end
            ST_SQR: r_acc <= r_acc - DIFF_W'(w_abs_sum * w_abs_sum);
            ST_MEAN: begin
                if (w_done) begin
                    r_mean <= r_job.sum[SUM_W-1] ? (~w_quot[MEAN_W-1:0] + MEAN_W'(1))
                                                 : w_quot[MEAN_W-1:0];
                end
            end
            ST_VAR: begin
                if (w_done) begin
                    r_var  <= w_quot[VAR_W-1:0];
                    r_rad  <= ROOT_RW'({w_quot[VAR_W-1:0], 16'h0});
                    r_rem  <= '0;
                    r_root <= '0;
                    r_rcnt <= ROOT_CW'(STD_W - 1);
                end
            end
            ST_ROOT: begin
                r_rad  <= {r_rad[ROOT_RW-3:0], 2'b00};
                r_rem  <= w_rge ? (w_rsh - w_trial) : w_rsh;
                r_root <= w_root_nx;
                r_rcnt <= r_rcnt - ROOT_CW'(1);
                if (r_rcnt == '0) begin
                    r_std <= w_root_nx;
                    r_cv  <= CV_POS_SAT;
                    r_bad <= 1'b1;
                end
            end
            ST_CV: begin
                if (w_done) begin
                    if (!r_mean[MEAN_W-1]) begin
                        if (w_quot > DIV_DW'(CV_POS_SAT)) begin
                            r_cv  <= CV_POS_SAT;
                            r_bad <= 1'b1;
                        end else begin
                            r_cv  <= w_quot[CV_W-1:0];
                            r_bad <= 1'b0;
                        end
                    end else begin
                        if (w_quot > DIV_DW'(CV_NEG_SAT)) begin
                            r_cv  <= CV_NEG_SAT;
                            r_bad <= 1'b1;
                        end else begin
                            r_cv  <= ~w_quot[CV_W-1:0] + CV_W'(1);
                            r_bad <= 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_tdata <= {r_job.n, r_cv, r_std, r_var, r_mean};
            o_tuser <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_tvalid = r_out_valid;

endmodule

// File: sim/mean_variance_cv_stats_test.sv
// Self-checking test of the run statistics block against an internal predictor.
module mean_variance_cv_stats_test;
    import mvcs_pkg::*;

    localparam int LIMIT = 2_000_000;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } t_req;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [CV_W-1:0]    cv;
        logic [STD_W-1:0]   sd;
        logic [VAR_W-1:0]   var_q;
        logic [MEAN_W-1:0]  mean;
        logic               bad;
    } t_stats;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic [15:0]         i_s_axis_tdata = '0;
    logic                i_s_axis_tlast = 1'b0;
    logic                i_m_axis_tready = 1'b0;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [TDATA_W-1:0]  o_m_axis_tdata;
    logic                o_m_axis_tuser;

    t_req   pending_reqs[$];
    t_stats expected_stats[$];
    int     errors = 0;
    int     cycles = 0;
    int     sent = 0;
    bit     calm;

    // Predictor state.
    longint unsigned acc_n = 0;
    longint          acc_sum = 0;
    longint unsigned acc_sq = 0;

    mean_variance_cv_stats u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Neither side idles while this stretch of requests is sent.
    assign calm = (sent >= 400) && (sent < 500);

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Accumulate one sample; on the last one, queue the expected statistics.
    task automatic predict_stats(input t_req rq);
        longint s, mean;
        longint unsigned a, d, t, v, sd, am, q, cv, bad;
        t_stats e;
        s = longint'($signed(rq.sample));
        if (acc_n < 65536) begin
            acc_n++;
            acc_sum += s;
            acc_sq += longint'(s * s);
        end
        if (!rq.last) return;
        mean = (acc_sum * 65536) / longint'(acc_n);
        a = acc_sum < 0 ? -acc_sum : acc_sum;
        d = acc_n * acc_sq - a * a;
        t = ((d / acc_n) << 16) + ((d % acc_n) << 16) / acc_n;
        v = t / acc_n;
        sd = isqrt(v << 16);
        bad = 0;
        if (mean == 0) begin
            cv = 64'h7FFFFFFF; bad = 1;
        end else begin
            am = mean < 0 ? -mean : mean;
            q = (sd << 16) / am;
            if (mean > 0) begin
                if (q > 64'h7FFFFFFF) begin cv = 64'h7FFFFFFF; bad = 1; end
                else cv = q;
            end else begin
                if (q > 64'h80000000) begin cv = 64'h80000000; bad = 1; end
                else cv = (0 - q) & 64'hFFFFFFFF;
            end
        end
        e.mean = mean[31:0];
        e.var_q = v[46:0];
        e.sd = sd[31:0];
        e.cv = cv[31:0];
        e.bad = bad[0];
        e.count = acc_n[16:0];
        expected_stats.push_back(e);
        acc_n = 0; acc_sum = 0; acc_sq = 0;
    endtask

    // Driver: offers queued sample requests with random gaps.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= pending_reqs[0].sample;
                    i_s_axis_tlast <= pending_reqs[0].last;
                    predict_stats(pending_reqs.pop_front());
                    sent <= sent + 1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= calm || ($urandom_range(99) >= 14);
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_stats got, e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.mean = o_m_axis_tdata[31:0];
            got.var_q = o_m_axis_tdata[78:32];
            got.sd = o_m_axis_tdata[110:79];
            got.cv = o_m_axis_tdata[142:111];
            got.count = o_m_axis_tdata[159:143];
            got.bad = o_m_axis_tuser;
            if (expected_stats.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                errors = errors + 1;
            end else begin
                e = expected_stats.pop_front();
                if (got.mean !== e.mean) begin
                    $display("%0t mean: expected %h actual %h", $time, e.mean, got.mean);
                    errors = errors + 1;
                end
                if (got.var_q !== e.var_q) begin
                    $display("%0t variance: expected %h actual %h", $time, e.var_q, got.var_q);
                    errors = errors + 1;
                end
                if (got.sd !== e.sd) begin
                    $display("%0t std: expected %h actual %h", $time, e.sd, got.sd);
                    errors = errors + 1;
                end
                if (got.cv !== e.cv) begin
                    $display("%0t cv: expected %h actual %h", $time, e.cv, got.cv);
                    errors = errors + 1;
                end
                if (got.bad !== e.bad) begin
                    $display("%0t cv_invalid: expected %b actual %b", $time, e.bad, got.bad);
                    errors = errors + 1;
                end
                if (got.count !== e.count) begin
                    $display("%0t count: expected %h actual %h", $time, e.count, got.count);
                    errors = errors + 1;
                end
            end
        end
    end

    task automatic add_req(input logic [15:0] smp, input logic lst);
        t_req r;
        r.sample = smp;
        r.last = lst;
        pending_reqs.push_back(r);
    endtask

    // Watchdog against a hung block.
    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int len, mode, k;
        logic [15:0] base;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: single samples at extremes, zero mean, negative mean,
        // large spread with tiny mean so cv saturates.
        add_req(16'h7FFF, 1'b1);
        add_req(16'h8000, 1'b1);
        add_req(16'h0000, 1'b1);
        add_req(16'h7FFF, 1'b0); add_req(16'h8000, 1'b0); add_req(16'h0001, 1'b1);
        add_req(16'h8000, 1'b0); add_req(16'h7FFF, 1'b1);
        add_req(16'hFFFF, 1'b0); add_req(16'hFFFD, 1'b1);
        add_req(16'h7FFF, 1'b0); add_req(16'h8001, 1'b0); add_req(16'h0001, 1'b1);
        add_req(16'h8000, 1'b0); add_req(16'h8000, 1'b0); add_req(16'h8000, 1'b1);
        add_req(16'h0005, 1'b0); add_req(16'h0005, 1'b1);
        add_req(16'hAAAA, 1'b0); add_req(16'h5555, 1'b1);
        // Random runs, mostly short.
        k = 0;
        while (k < 850) begin
            len = $urandom_range(12, 1);
            if ($urandom_range(15) == 0) len = $urandom_range(60, 13);
            mode = $urandom_range(3);
            base = 16'($urandom);
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0: add_req(16'($urandom), i == len - 1);
                    1: add_req(base + 16'($urandom_range(7)), i == len - 1);
                    2: add_req((i % 2) ? 16'h8000 : 16'h7FFF, i == len - 1);
                    default: add_req($urandom_range(3) == 0 ? base : -base, i == len - 1);
                endcase
            end
            k += len;
        end
        wait (pending_reqs.size() == 0);
        wait (expected_stats.size() == 0);
        repeat (600) @(posedge i_clk);
        if (errors == 0 && expected_stats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
